// ===== rtl/core/sorted_priority_queue_unit_macros.svh =====
// Assertion macros for the sorted priority queue.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge out of reset.
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted priority queue assertion failed");

// When the condition holds, the consequence must hold in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted priority queue assertion failed");

`else

`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned PAY_W   = 8;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic              operation;
    logic [PRIO_W-1:0] priority_req;
    logic [PAY_W-1:0]  payload;
  } spq_in_t;

  typedef struct packed {
    spq_status_e        status;
    logic [PRIO_W-1:0]  out_priority;
    logic [PAY_W-1:0]   out_payload;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } spq_out_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
  } spq_entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t entry;
  } spq_cell_ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic          clk_i,
  input  spq_cell_ctl_t ctl_i,
  input  logic          occ_i,
  input  logic          left_ge_i,
  input  spq_entry_t    left_entry_i,
  input  spq_entry_t    right_entry_i,
  output spq_entry_t    entry_o,
  output logic          ge_o
);

  spq_entry_t entry_q, entry_d;

  // An occupied slot whose priority is at least the new one stays in front of it.
  assign ge_o = occ_i && (entry_q.prio >= ctl_i.entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.enq) begin
      if (ge_o) begin
        entry_d = entry_q;
      end else if (left_ge_i) begin
        entry_d = ctl_i.entry;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctl_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/core/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps

// Bounded priority queue held as a chain of DEPTH cells sorted from the front
// (cell 0) to the back. An item is first registered; then, once the output
// register is free or being taken, all cells compare their priority with it in
// parallel and the chain shifts by one place in a single step (not for a refused
// request), while the result is loaded into the output register. The input
// stalls while an item is held, so no new item is accepted until the last has
// gone to the output. Dequeue returns the highest priority; equal priorities
// leave in arrival order. The capacity register may only be written while idle.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  spq_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spq_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic             cmd_valid_q;
  spq_in_t          cmd_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] capacity_q;
  logic             out_valid_q, out_valid_d;
  spq_out_t         out_q, out_d;

  logic             exec;
  logic [CMP_W-1:0] cap_raw, cap_eff, count_ext, count_d_ext;
  spq_cell_ctl_t    cell_ctl;

  spq_entry_t       entry_w [DEPTH];
  logic [DEPTH-1:0] ge_w;
  logic [DEPTH-1:0] occ_w;

  assign in_stall_o = cmd_valid_q;
  assign exec       = cmd_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      cmd_valid_q <= 1'b1;
    end else if (exec) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Capacity in effect is the register saturated to the range one to DEPTH.
  assign cap_raw   = CMP_W'(capacity_q);
  assign count_ext = CMP_W'(count_q);

  always_comb begin
    cap_eff = cap_raw;
    if (cap_raw == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_raw > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end
  end

  always_comb begin
    cell_ctl.enq   = 1'b0;
    cell_ctl.deq   = 1'b0;
    cell_ctl.entry = '{prio: cmd_q.priority_req, payload: cmd_q.payload};
    count_d        = count_q;
    out_d          = '0;
    out_d.status   = ST_DONE;
    if (cmd_q.operation == OP_ENQ) begin
      if (count_ext >= cap_eff) begin
        out_d.status = ST_FULL;
      end else begin
        cell_ctl.enq = exec;
        count_d      = count_q + CNT_W'(1);
      end
    end else begin
      if (count_q == '0) begin
        out_d.status = ST_EMPTY;
      end else begin
        cell_ctl.deq       = exec;
        count_d            = count_q - CNT_W'(1);
        out_d.out_priority = entry_w[0].prio;
        out_d.out_payload  = entry_w[0].payload;
      end
    end
    count_d_ext    = CMP_W'(count_d);
    out_d.count    = COUNT_W'(count_d);
    out_d.is_empty = (count_d == '0);
    out_d.is_full  = (count_d_ext >= cap_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (exec) begin
      count_q <= count_d;
    end
  end

  assign out_valid_d = exec || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    spq_entry_t left_entry, right_entry;
    logic       left_ge;

    assign occ_w[k] = (CNT_W'(k) < count_q);

    if (k == 0) begin : g_front
      assign left_entry = cell_ctl.entry;
      assign left_ge    = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[k-1];
      assign left_ge    = ge_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_back
      assign right_entry = entry_w[k];
    end else begin : g_inner
      assign right_entry = entry_w[k+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .occ_i        (occ_w[k]),
      .left_ge_i    (left_ge),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .entry_o      (entry_w[k]),
      .ge_o         (ge_w[k])
    );
  end

  `SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))
  `SPQ_ASSERT_NEXT(a_enq_count, exec && cell_ctl.enq, count_q == $past(count_q) + CNT_W'(1))
  `SPQ_ASSERT_NEXT(a_deq_count, exec && cell_ctl.deq, count_q == $past(count_q) - CNT_W'(1))
  `SPQ_ASSERT(a_front_sorted, !occ_w[1] || (entry_w[0].prio >= entry_w[1].prio))
  `SPQ_ASSERT(a_empty_flag, !out_valid_o || (out_data_o.is_empty == (out_data_o.count == '0)))

endmodule

// ===== tb/sv/spq_result_checker.sv =====
`timescale 1ns / 1ps

module spq_result_checker
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  spq_in_t          in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  spq_out_t         out_data_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output int               err_cnt_o,
  output int               pending_o,
  output int               accepted_o,
  output int               full_rej_o,
  output int               empty_rej_o
);

  // Entries held by the queue, front first.
  spq_entry_t       shadow_entries[$];
  spq_out_t         awaited_results[$];
  logic [CAP_W-1:0] capacity_reg;

  int err_cnt   = 0;
  int pending   = 0;
  int accepted  = 0;
  int full_rej  = 0;
  int empty_rej = 0;

  assign err_cnt_o   = err_cnt;
  assign pending_o   = pending;
  assign accepted_o  = accepted;
  assign full_rej_o  = full_rej;
  assign empty_rej_o = empty_rej;

  function automatic spq_out_t apply_request(spq_in_t req);
    spq_out_t   res;
    spq_entry_t ent;
    int         cap;
    int         pos;
    cap = capacity_reg;
    if (cap == 0) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    res = '0;
    res.status = ST_DONE;
    if (req.operation == OP_ENQ) begin
      if (shadow_entries.size() >= cap) begin
        res.status = ST_FULL;
      end else begin
        // The new entry goes behind every entry of equal or higher priority.
        pos = shadow_entries.size();
        while (pos > 0 && shadow_entries[pos-1].prio < req.priority_req) pos--;
        ent.prio    = req.priority_req;
        ent.payload = req.payload;
        shadow_entries.insert(pos, ent);
      end
    end else if (shadow_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      ent = shadow_entries.pop_front();
      res.out_priority = ent.prio;
      res.out_payload  = ent.payload;
    end
    res.count    = COUNT_W'(shadow_entries.size());
    res.is_empty = (shadow_entries.size() == 0);
    res.is_full  = (shadow_entries.size() >= cap);
    return res;
  endfunction

  task automatic compare_result(spq_out_t exp_r, spq_out_t act_r);
    if (act_r.status !== exp_r.status) begin
      $error("status: expected %0d, actual %0d", exp_r.status, act_r.status);
      err_cnt++;
    end
    if (act_r.out_priority !== exp_r.out_priority) begin
      $error("out_priority: expected %h, actual %h", exp_r.out_priority, act_r.out_priority);
      err_cnt++;
    end
    if (act_r.out_payload !== exp_r.out_payload) begin
      $error("out_payload: expected %h, actual %h", exp_r.out_payload, act_r.out_payload);
      err_cnt++;
    end
    if (act_r.count !== exp_r.count) begin
      $error("count: expected %0d, actual %0d", exp_r.count, act_r.count);
      err_cnt++;
    end
    if (act_r.is_empty !== exp_r.is_empty) begin
      $error("is_empty: expected %b, actual %b", exp_r.is_empty, act_r.is_empty);
      err_cnt++;
    end
    if (act_r.is_full !== exp_r.is_full) begin
      $error("is_full: expected %b, actual %b", exp_r.is_full, act_r.is_full);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spq_out_t exp_r;
    if (!rst_ni) begin
      shadow_entries.delete();
      awaited_results.delete();
      capacity_reg = CAP_RESET;
      pending      = 0;
    end else begin
      // A result transfer never belongs to a request taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          err_cnt++;
        end else begin
          exp_r = awaited_results.pop_front();
          pending--;
          compare_result(exp_r, out_data_i);
        end
      end
      if (cfg_we_i) capacity_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        exp_r = apply_request(in_data_i);
        if (exp_r.status == ST_FULL) full_rej++;
        if (exp_r.status == ST_EMPTY) empty_rej++;
        awaited_results.push_back(exp_r);
        pending++;
        accepted++;
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int LONG_HOLD      = 60;
  localparam int RAND_PER_PHASE = 175;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  spq_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  spq_out_t         out_data;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int err_cnt;
  int pending;
  int accepted;
  int full_rej;
  int empty_rej;
  int cap_writes;
  int cycle_cnt;

  bit tx_quiet;
  bit long_hold_req;
  bit long_hold_done;

  sorted_priority_queue_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  spq_result_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .accepted_o  (accepted),
    .full_rej_o  (full_rej),
    .empty_rej_o (empty_rej)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic spq_in_t make_request(logic op, logic [PRIO_W-1:0] prio,
                                           logic [PAY_W-1:0] pay);
    spq_in_t req;
    req.operation    = op;
    req.priority_req = prio;
    req.payload      = pay;
    return req;
  endfunction

  // Mostly back to back, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The queue tends to fill or to drain, so both full and empty are reached.
  function automatic spq_in_t random_request(bit filling);
    spq_in_t req;
    int      r;
    if (filling) req.operation = ($urandom_range(0, 99) < 75) ? OP_ENQ : OP_DEQ;
    else req.operation = ($urandom_range(0, 99) < 25) ? OP_ENQ : OP_DEQ;
    r = $urandom_range(0, 9);
    // A narrow range of priorities makes ties common.
    if (r < 4) req.priority_req = PRIO_W'($urandom_range(0, 3));
    else if (r == 4) req.priority_req = '0;
    else if (r == 5) req.priority_req = '1;
    else req.priority_req = PRIO_W'($urandom);
    req.payload = PAY_W'($urandom);
    return req;
  endfunction

  task automatic send_item(spq_in_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(int value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = CAP_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    cap_writes++;
  endtask

  initial begin : receiver
    int burst;
    int quiet_left;
    int r;
    bit quiet;
    out_stall      = 1'b0;
    long_hold_done = 1'b0;
    burst          = 0;
    quiet_left     = 0;
    quiet          = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        // Hold results back long enough that the block stalls its input.
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall      = 1'b0;
        long_hold_done = 1'b1;
      end else begin
        if (quiet_left == 0) begin
          quiet      = ($urandom_range(0, 3) == 0);
          quiet_left = $urandom_range(50, 300);
        end
        quiet_left--;
        if (burst > 0) begin
          burst--;
          out_stall = 1'b1;
        end else if (quiet) begin
          out_stall = 1'b0;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            out_stall = 1'b0;
          end else if (r < 96) begin
            out_stall = 1'b1;
            burst     = $urandom_range(0, 2);
          end else begin
            out_stall = 1'b1;
            burst     = $urandom_range(8, 40);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int cap_plan[10];
    bit filling;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    tx_quiet       = 1'b0;
    long_hold_req  = 1'b0;
    cap_writes     = 0;
    filling        = 1'b1;
    cap_plan       = '{31, 16, 3, 17, 1, 0, 8, 0, 16, 0};
    cap_plan[7]    = $urandom_range(1, 16);
    cap_plan[9]    = $urandom_range(0, 31);
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset capacity: empty rejection, extremes, and ties leaving in arrival order.
    send_item(make_request(OP_DEQ, '0, '0));
    send_item(make_request(OP_ENQ, 16'h0000, 8'h00));
    send_item(make_request(OP_ENQ, 16'hFFFF, 8'hFF));
    send_item(make_request(OP_ENQ, 16'h8000, 8'h11));
    send_item(make_request(OP_ENQ, 16'h8000, 8'h22));
    send_item(make_request(OP_ENQ, 16'h8000, 8'h33));
    repeat (6) send_item(make_request(OP_DEQ, 16'hFFFF, 8'hFF));

    // Small capacity: an enqueue into a full queue is rejected.
    write_capacity(2);
    send_item(make_request(OP_ENQ, 16'h1234, 8'hAA));
    send_item(make_request(OP_ENQ, 16'h5678, 8'h55));
    send_item(make_request(OP_ENQ, 16'hFFFF, 8'hFF));

    // Capacity lowered below the count: entries stay, enqueues are refused.
    write_capacity(1);
    send_item(make_request(OP_ENQ, 16'h0001, 8'h01));
    repeat (3) send_item(make_request(OP_DEQ, '0, '0));

    // A capacity of zero behaves as one.
    write_capacity(0);
    send_item(make_request(OP_ENQ, 16'h00FF, 8'h0F));
    send_item(make_request(OP_ENQ, 16'h0100, 8'hF0));
    send_item(make_request(OP_DEQ, '0, '0));

    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      if (p == 0) long_hold_req = 1'b1;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (i % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        if (p == 0 && i < 40) tx_quiet = 1'b1;
        if ($urandom_range(0, 11) == 0) filling = !filling;
        send_item(random_request(filling));
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Run covered %0d requests under %0d capacity settings; %0d results checked.",
             accepted, cap_writes + 1, accepted - pending);
    $display("Enqueues refused as full: %0d, dequeues refused as empty: %0d.",
             full_rej, empty_rej);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
tb/sv/spq_result_checker.sv
tb/sv/tb.sv
